// File: rtl/tce_pkg.sv
// tce_pkg: sizes, opcodes, status and register codes of the execute unit
// shared by the execute unit, its checker and the testbench; no dependencies
package tce_pkg;

	localparam int NUM_REGS       = 8;
	localparam int NUM_PROCS      = 4;
	localparam int WORDS_PER_PROC = 1024;
	localparam int DATA_WIDTH     = 32;

	localparam int REG_AW    = $clog2(NUM_REGS);
	localparam int PROC_W    = $clog2(NUM_PROCS);
	localparam int ADDR_W    = $clog2(WORDS_PER_PROC);
	localparam int PMEM_AW   = PROC_W + ADDR_W;
	localparam int FRAME_LEN = NUM_REGS + 3;
	localparam int K_W       = $clog2(FRAME_LEN);

	localparam logic [ADDR_W-1:0] SP_RESET = ADDR_W'(WORDS_PER_PROC - 1);
	localparam logic [PROC_W-1:0] KERNEL   = '0;

	typedef enum logic [5:0] {
		OP_NOPER = 6'd0,  OP_DMPRG = 6'd1,  OP_MSTRM = 6'd2,  OP_USERM = 6'd3,
		OP_NINTR = 6'd4,  OP_INTRP = 6'd5,  OP_SETRI = 6'd6,  OP_SETRG = 6'd7,
		OP_SETPR = 6'd8,  OP_CPPRG = 6'd9,  OP_ADDRG = 6'd10, OP_SUBRG = 6'd11,
		OP_PSHRG = 6'd12, OP_POPRG = 6'd13, OP_JMABS = 6'd14, OP_JMPTO = 6'd15,
		OP_JZERO = 6'd16, OP_JNZRO = 6'd17, OP_JMBSI = 6'd18, OP_JMTOI = 6'd19,
		OP_JZROI = 6'd20, OP_JNZRI = 6'd21, OP_LDMEM = 6'd22, OP_STMEM = 6'd23,
		OP_LDSHM = 6'd24, OP_STSHM = 6'd25, OP_LDPSW = 6'd26, OP_SPSWR = 6'd27,
		OP_LDPRM = 6'd28, OP_STPRM = 6'd29, OP_WKCPU = 6'd30, OP_GETI0 = 6'd31,
		OP_GETI1 = 6'd32, OP_CLLSB = 6'd33, OP_RETSB = 6'd34, OP_CLINT = 6'd35,
		OP_SPECP = 6'd36, OP_SDOWN = 6'd37
	} opcode_t;

	localparam logic [5:0] OP_LAST = 6'd37;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_PRIV  = 3'd1,
		ST_RANGE = 3'd2,
		ST_CONS  = 3'd3,
		ST_ILL   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CON_NONE = 2'd0,
		CON_IN   = 2'd1,
		CON_OUT  = 2'd2
	} console_t;

	typedef enum logic [2:0] {
		CFG_FRAME   = 3'd0,
		CFG_PIDSLOT = 3'd1,
		CFG_CONSOLE = 3'd2,
		CFG_LASTPRC = 3'd3,
		CFG_AUX     = 3'd4
	} cfg_idx_t;

	localparam logic OPN_EXEC = 1'b0;
	localparam logic OPN_INTR = 1'b1;

endpackage

// File: rtl/tce_in_if.sv
// tce_in_if: input channel of the execute unit, one instruction or interrupt word
// depends on nothing but the port widths of the work fields
interface tce_in_if;
	logic               valid;
	logic               ready;
	logic               operation;
	logic [5:0]         opcode;
	logic [2:0]         reg_a;
	logic [2:0]         reg_b;
	logic [2:0]         reg_c;
	logic signed [31:0] immediate;
	logic [7:0]         interrupt_number;

	modport source (output valid, operation, opcode, reg_a, reg_b, reg_c, immediate,
		interrupt_number, input ready);
	modport sink (input valid, operation, opcode, reg_a, reg_b, reg_c, immediate,
		interrupt_number, output ready);
endinterface

// File: rtl/tce_out_if.sv
// tce_out_if: result channel of the execute unit, machine status after each word
// depends on nothing but the port widths of the result fields
interface tce_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         status;
	logic [9:0]         program_counter;
	logic [1:0]         process_number;
	logic               master_mode;
	logic               interruptible;
	logic               running;
	logic [1:0]         console_request;
	logic               signal_valid;
	logic signed [31:0] signal_target;
	logic signed [31:0] signal_data_a;
	logic signed [31:0] signal_data_b;

	modport source (output valid, status, program_counter, process_number, master_mode,
		interruptible, running, console_request, signal_valid, signal_target,
		signal_data_a, signal_data_b, input ready);
	modport sink (input valid, status, program_counter, process_number, master_mode,
		interruptible, running, console_request, signal_valid, signal_target,
		signal_data_a, signal_data_b, output ready);
endinterface

// File: rtl/tce_ram.sv
// tce_ram: generic single write, single read memory with registered read data
// no dependencies
module tce_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: rtl/toy_cpu_execute_unit.sv
// toy_cpu_execute_unit: execute stage with register file, process and shared memories
// depends on tce_pkg, tce_in_if, tce_out_if and tce_ram
//
// channel  dir  handshake      carries
// in_ch    in   valid/ready    operation, opcode, reg_a/b/c, immediate, interrupt_number
// out_ch   out  valid/ready    status, pc, process, mode, flags, console, signal words
// cfg      in   cfg_we         cfg_idx selects register, cfg_data value
//
// a word passes S_RA to S_RD, three register file reads through its single port, then
// S_EXE and S_DONE; loads add S_LD for the registered memory read; LDPSW walks the frame
// in S_LP_RD/S_LP_WR, an interrupt from a user process saves it in S_SV_RD/S_SV_WR
// reset clears control state and register valid bits; memories are not cleared
// in_ch is ready only while idle; a finished result waits in the output register
module toy_cpu_execute_unit (
	input  logic        clk,
	input  logic        arst_n,
	tce_in_if.sink      in_ch,
	tce_out_if.source   out_ch,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [31:0] cfg_data
);
	localparam int DW = tce_pkg::DATA_WIDTH;
	localparam int AW = tce_pkg::ADDR_W;
	localparam int PW = tce_pkg::PROC_W;
	localparam int RW = tce_pkg::REG_AW;
	localparam int KW = tce_pkg::K_W;

	typedef enum logic [3:0] {
		S_IDLE, S_RA, S_RB, S_RC, S_RD, S_EXE, S_LD, S_LP_RD, S_LP_WR,
		S_SV_RD, S_SV_WR, S_PID, S_VEC, S_VECW, S_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic [AW-1:0] frame_q, pidslot_q, console_q;
	logic [1:0]    lastproc_q;
	logic [31:0]   aux_q;

	// machine state
	logic [AW-1:0]           pc_q, sp_q;
	logic [PW-1:0]           cp_q;
	logic                    mode_q, ie_q, run_q;
	logic [tce_pkg::NUM_REGS-1:0] rvalid_q;

	// latched word
	logic          opn_q;
	logic [5:0]    opc_q;
	logic [2:0]    ia_q, ib_q, ic_q;
	logic [31:0]   imm_q;
	logic [7:0]    intn_q;
	logic [DW-1:0] a_q, b_q, c_q;
	logic [AW-1:0] vec_q;
	logic [KW-1:0] k_q;

	// result word
	logic          ov_q;
	logic [2:0]    st_q;
	logic [1:0]    con_q;
	logic          sig_q;
	logic [31:0]   sgt_q, sga_q, sgb_q;

	// rams
	logic          r_we, rd_vld_q;
	logic [RW-1:0] r_waddr, r_raddr;
	logic [DW-1:0] r_wdata, r_rd, regdata;
	logic          p_we;
	logic [tce_pkg::PMEM_AW-1:0] p_waddr, p_raddr;
	logic [DW-1:0] p_wdata, p_rd;
	logic          s_we;
	logic [AW-1:0] s_waddr, s_raddr;
	logic [DW-1:0] s_wdata, s_rd;

	tce_ram #(.WIDTH(DW), .DEPTH(tce_pkg::NUM_REGS)) u_regs (
		.clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata), .raddr(r_raddr),
		.rdata(r_rd));
	tce_ram #(.WIDTH(DW), .DEPTH(tce_pkg::NUM_PROCS * tce_pkg::WORDS_PER_PROC)) u_pmem (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata), .raddr(p_raddr),
		.rdata(p_rd));
	tce_ram #(.WIDTH(DW), .DEPTH(tce_pkg::WORDS_PER_PROC)) u_shm (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr),
		.rdata(s_rd));

	// a never written register reads as zero
	assign regdata = rd_vld_q ? r_rd : '0;

	logic [AW-1:0] aw, bw, immw, frame_k;
	logic [PW-1:0] ap;
	logic [RW-1:0] ra, rb, rc, kreg;
	logic          priv, ranged, con_hit, ex_go, is_intr;
	logic [2:0]    ex_status;
	logic [DW-1:0] ld_data;

	always_comb begin
		aw      = a_q[AW-1:0];
		bw      = b_q[AW-1:0];
		immw    = imm_q[AW-1:0];
		ap      = a_q[PW-1:0];
		ra      = ia_q[RW-1:0];
		rb      = ib_q[RW-1:0];
		rc      = ic_q[RW-1:0];
		kreg    = RW'(k_q - KW'(3));
		frame_k = frame_q + AW'(k_q);
		priv    = (opc_q == tce_pkg::OP_LDPSW) || (opc_q == tce_pkg::OP_SPSWR) ||
			(opc_q == tce_pkg::OP_LDPRM) || (opc_q == tce_pkg::OP_STPRM) ||
			(opc_q == tce_pkg::OP_SDOWN);
		ranged  = (opc_q == tce_pkg::OP_SETPR) || (opc_q == tce_pkg::OP_LDPSW) ||
			(opc_q == tce_pkg::OP_SPSWR) || (opc_q == tce_pkg::OP_LDPRM) ||
			(opc_q == tce_pkg::OP_STPRM);
		con_hit = (opc_q == tce_pkg::OP_STMEM) && mode_q && (cp_q == tce_pkg::KERNEL) &&
			(aw == console_q);
		if (opn_q == tce_pkg::OPN_INTR) begin
			ex_status = tce_pkg::ST_OK;
		end else if (opc_q > tce_pkg::OP_LAST) begin
			ex_status = tce_pkg::ST_ILL;
		end else if (priv && !mode_q) begin
			ex_status = tce_pkg::ST_PRIV;
		end else if (ranged && (a_q >= DW'(tce_pkg::NUM_PROCS))) begin
			ex_status = tce_pkg::ST_RANGE;
		end else if (con_hit && (b_q != DW'(0)) && (b_q != DW'(1))) begin
			ex_status = tce_pkg::ST_CONS;
		end else begin
			ex_status = tce_pkg::ST_OK;
		end
		ex_go   = (opn_q == tce_pkg::OPN_EXEC) && (ex_status == tce_pkg::ST_OK);
		is_intr = (opn_q == tce_pkg::OPN_INTR) || (ex_go && (opc_q == tce_pkg::OP_CLINT));
		ld_data = (opc_q == tce_pkg::OP_LDSHM) ? s_rd : p_rd;

		r_we = 1'b0; r_waddr = ra; r_wdata = '0; r_raddr = ra;
		p_we = 1'b0; p_waddr = '0; p_wdata = '0; p_raddr = '0;
		s_we = 1'b0; s_waddr = aw; s_wdata = b_q; s_raddr = aw;

		case (state_q)
			S_RB: r_raddr = rb;
			S_RC: r_raddr = rc;
			S_EXE: begin
				if (ex_go) begin
					case (opc_q)
						tce_pkg::OP_SETRI: begin r_we = 1'b1; r_wdata = DW'(imm_q); end
						tce_pkg::OP_SETRG: begin r_we = 1'b1; r_wdata = b_q; end
						tce_pkg::OP_CPPRG: begin r_we = 1'b1; r_wdata = DW'(cp_q); end
						tce_pkg::OP_ADDRG: begin r_we = 1'b1; r_wdata = b_q + c_q; end
						tce_pkg::OP_SUBRG: begin r_we = 1'b1; r_wdata = b_q - c_q; end
						tce_pkg::OP_GETI0: begin r_we = 1'b1; r_wdata = DW'(lastproc_q); end
						tce_pkg::OP_GETI1: begin r_we = 1'b1; r_wdata = DW'(aux_q); end
						tce_pkg::OP_PSHRG: begin
							p_we = 1'b1; p_waddr = {cp_q, sp_q - aw}; p_wdata = b_q;
						end
						tce_pkg::OP_POPRG: p_raddr = {cp_q, sp_q + aw};
						tce_pkg::OP_LDMEM: p_raddr = {cp_q, aw};
						tce_pkg::OP_STMEM: begin
							p_we = !con_hit; p_waddr = {cp_q, aw}; p_wdata = b_q;
						end
						tce_pkg::OP_STSHM: s_we = 1'b1;
						tce_pkg::OP_SPSWR: begin
							p_we = 1'b1; p_waddr = {ap, frame_q + AW'(3) + AW'(ib_q)};
							p_wdata = c_q;
						end
						tce_pkg::OP_LDPRM: p_raddr = {ap, bw};
						tce_pkg::OP_STPRM: begin
							p_we = 1'b1; p_waddr = {ap, bw}; p_wdata = c_q;
						end
						tce_pkg::OP_CLLSB: begin
							p_we = 1'b1; p_waddr = {cp_q, sp_q - aw}; p_wdata = DW'(pc_q);
						end
						tce_pkg::OP_RETSB: p_raddr = {cp_q, sp_q};
						default: ;
					endcase
				end
			end
			S_LD: begin
				if (opc_q != tce_pkg::OP_RETSB) begin
					r_we    = 1'b1;
					r_waddr = (opc_q == tce_pkg::OP_LDPRM) ? rc : rb;
					r_wdata = ld_data;
				end
			end
			S_LP_RD: p_raddr = {ap, frame_k};
			S_LP_WR: begin
				r_we    = (k_q >= KW'(3));
				r_waddr = kreg;
				r_wdata = p_rd;
			end
			S_SV_RD: r_raddr = kreg;
			S_SV_WR: begin
				p_we    = 1'b1;
				p_waddr = {cp_q, frame_k};
				if (k_q == KW'(0)) begin
					p_wdata = DW'(sp_q);
				end else if (k_q == KW'(1)) begin
					p_wdata = DW'(pc_q);
				end else if (k_q == KW'(2)) begin
					p_wdata = DW'(mode_q);
				end else begin
					p_wdata = regdata;
				end
			end
			S_PID: begin
				p_we = 1'b1; p_waddr = {tce_pkg::KERNEL, pidslot_q}; p_wdata = DW'(cp_q);
			end
			S_VEC: p_raddr = {tce_pkg::KERNEL, vec_q};
			default: ;
		endcase
	end

	assign in_ch.ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			frame_q    <= '0;
			pidslot_q  <= AW'(1);
			console_q  <= AW'(2);
			lastproc_q <= 2'd3;
			aux_q      <= '0;
			pc_q       <= '0;
			sp_q       <= tce_pkg::SP_RESET;
			cp_q       <= tce_pkg::KERNEL;
			mode_q     <= 1'b1;
			ie_q       <= 1'b0;
			run_q      <= 1'b1;
			rvalid_q   <= '0;
			rd_vld_q   <= 1'b0;
			ov_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					tce_pkg::CFG_FRAME:   frame_q    <= cfg_data[AW-1:0];
					tce_pkg::CFG_PIDSLOT: pidslot_q  <= cfg_data[AW-1:0];
					tce_pkg::CFG_CONSOLE: console_q  <= cfg_data[AW-1:0];
					tce_pkg::CFG_LASTPRC: lastproc_q <= cfg_data[1:0];
					tce_pkg::CFG_AUX:     aux_q      <= cfg_data;
					default: ;
				endcase
			end
			rd_vld_q <= rvalid_q[r_raddr];
			if (r_we) begin
				rvalid_q[r_waddr] <= 1'b1;
			end
			if (ov_q && out_ch.ready) begin
				ov_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						opn_q  <= in_ch.operation;
						opc_q  <= in_ch.opcode;
						ia_q   <= in_ch.reg_a;
						ib_q   <= in_ch.reg_b;
						ic_q   <= in_ch.reg_c;
						imm_q  <= in_ch.immediate;
						intn_q <= in_ch.interrupt_number;
						state_q <= S_RA;
					end
				end
				S_RA: state_q <= S_RB;
				S_RB: begin a_q <= regdata; state_q <= S_RC; end
				S_RC: begin b_q <= regdata; state_q <= S_RD; end
				S_RD: begin c_q <= regdata; state_q <= S_EXE; end
				S_EXE: begin
					st_q  <= ex_status;
					con_q <= tce_pkg::CON_NONE;
					sig_q <= 1'b0;
					sgt_q <= '0;
					sga_q <= '0;
					sgb_q <= '0;
					k_q   <= '0;
					vec_q <= (opn_q == tce_pkg::OPN_INTR) ? AW'(intn_q) : aw;
					state_q <= S_DONE;
					if (is_intr) begin
						ie_q    <= 1'b0;
						state_q <= (cp_q != tce_pkg::KERNEL) ? S_SV_RD : S_VEC;
					end else if (ex_go) begin
						case (opc_q)
							tce_pkg::OP_MSTRM: mode_q <= 1'b1;
							tce_pkg::OP_USERM: mode_q <= 1'b0;
							tce_pkg::OP_NINTR: ie_q <= 1'b0;
							tce_pkg::OP_INTRP: ie_q <= 1'b1;
							tce_pkg::OP_SETPR: cp_q <= ap;
							tce_pkg::OP_JMABS: pc_q <= aw;
							tce_pkg::OP_JMPTO: pc_q <= pc_q + aw;
							tce_pkg::OP_JZERO: if (a_q == '0) pc_q <= pc_q + bw;
							tce_pkg::OP_JNZRO: if (a_q != '0) pc_q <= pc_q + bw;
							tce_pkg::OP_JMBSI: pc_q <= immw;
							tce_pkg::OP_JMTOI: pc_q <= pc_q + immw;
							tce_pkg::OP_JZROI: if (a_q == '0) pc_q <= pc_q + immw;
							tce_pkg::OP_JNZRI: if (a_q != '0) pc_q <= pc_q + immw;
							tce_pkg::OP_STMEM: begin
								if (con_hit) begin
									con_q <= (b_q == '0) ? tce_pkg::CON_IN : tce_pkg::CON_OUT;
								end
							end
							tce_pkg::OP_WKCPU: begin
								sig_q <= 1'b1;
								sgt_q <= a_q[31:0];
								sga_q <= b_q[31:0];
								sgb_q <= c_q[31:0];
							end
							tce_pkg::OP_CLLSB: begin
								sp_q <= sp_q - aw;
								pc_q <= bw;
							end
							tce_pkg::OP_SDOWN: run_q <= 1'b0;
							tce_pkg::OP_POPRG, tce_pkg::OP_LDMEM, tce_pkg::OP_LDSHM,
							tce_pkg::OP_LDPRM, tce_pkg::OP_RETSB: state_q <= S_LD;
							tce_pkg::OP_LDPSW: state_q <= S_LP_RD;
							default: ;
						endcase
					end
				end
				S_LD: begin
					if (opc_q == tce_pkg::OP_RETSB) begin
						pc_q <= ld_data[AW-1:0];
						sp_q <= sp_q + aw;
					end
					state_q <= S_DONE;
				end
				S_LP_RD: state_q <= S_LP_WR;
				S_LP_WR: begin
					if (k_q == KW'(0)) sp_q <= p_rd[AW-1:0];
					if (k_q == KW'(1)) pc_q <= p_rd[AW-1:0];
					if (k_q == KW'(2)) mode_q <= p_rd[0];
					if (k_q == KW'(tce_pkg::FRAME_LEN - 1)) begin
						cp_q    <= ap;
						ie_q    <= 1'b1;
						state_q <= S_DONE;
					end else begin
						k_q     <= k_q + KW'(1);
						state_q <= S_LP_RD;
					end
				end
				S_SV_RD: state_q <= S_SV_WR;
				S_SV_WR: begin
					if (k_q == KW'(tce_pkg::FRAME_LEN - 1)) begin
						state_q <= S_PID;
					end else begin
						k_q     <= k_q + KW'(1);
						state_q <= S_SV_RD;
					end
				end
				S_PID: begin
					cp_q    <= tce_pkg::KERNEL;
					state_q <= S_VEC;
				end
				S_VEC: begin
					mode_q  <= 1'b1;
					state_q <= S_VECW;
				end
				S_VECW: begin
					pc_q    <= p_rd[AW-1:0];
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!ov_q || out_ch.ready) begin
						ov_q    <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output word register, loaded when leaving S_DONE
	logic [9:0] o_pc_q;
	logic [1:0] o_cp_q;
	logic       o_mode_q, o_ie_q, o_run_q;

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!ov_q || out_ch.ready)) begin
			out_ch.status          <= st_q;
			o_pc_q                 <= 10'(pc_q);
			o_cp_q                 <= 2'(cp_q);
			o_mode_q               <= mode_q;
			o_ie_q                 <= ie_q;
			o_run_q                <= run_q;
			out_ch.console_request <= con_q;
			out_ch.signal_valid    <= sig_q;
			out_ch.signal_target   <= sgt_q;
			out_ch.signal_data_a   <= sga_q;
			out_ch.signal_data_b   <= sgb_q;
		end
	end

	assign out_ch.valid           = ov_q;
	assign out_ch.program_counter = o_pc_q;
	assign out_ch.process_number  = o_cp_q;
	assign out_ch.master_mode     = o_mode_q;
	assign out_ch.interruptible   = o_ie_q;
	assign out_ch.running         = o_run_q;
endmodule

// File: sim/tce_exec_checker.sv
// tce_exec_checker: watches the channels and config port of the execute unit,
// predicts each result word from its own copy of the machine state and compares
// depends on tce_pkg, tce_in_if and tce_out_if
module tce_exec_checker
	import tce_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	tce_in_if           in_ch,
	tce_out_if          out_ch,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [31:0] cfg_data,
	output int          mismatches,
	output int          words_seen
);

	typedef struct packed {
		logic [2:0]  status;
		logic [9:0]  pc;
		logic [1:0]  proc;
		logic        mode;
		logic        ie;
		logic        run;
		logic [1:0]  con;
		logic        sig;
		logic [31:0] tgt;
		logic [31:0] da;
		logic [31:0] db;
	} machine_status_t;

	logic [31:0] gpr [8];
	logic [31:0] pmem [4096];
	logic [31:0] smem [1024];
	logic [9:0]  pc, sp, frame, pidslot, con_addr;
	logic [1:0]  cur, last_proc;
	logic [31:0] aux;
	logic        mode, ie, run;
	machine_status_t status_q [$];

	function automatic logic [11:0] paddr(input logic [1:0] p, input logic [9:0] a);
		return {p, a};
	endfunction

	task automatic enter_interrupt(input logic [9:0] vec);
		ie = 1'b0;
		if (cur != KERNEL) begin
			pmem[paddr(cur, frame)] = {22'd0, sp};
			pmem[paddr(cur, frame + 10'd1)] = {22'd0, pc};
			pmem[paddr(cur, frame + 10'd2)] = {31'd0, mode};
			for (int k = 0; k < 8; k++)
				pmem[paddr(cur, frame + 10'd3 + 10'(k))] = gpr[k];
			pmem[paddr(KERNEL, pidslot)] = {30'd0, cur};
			cur = KERNEL;
		end
		mode = 1'b1;
		pc = pmem[paddr(KERNEL, vec)][9:0];
	endtask

	// word indexes wrap, and 2^32 is a multiple of the memory depth: low bits suffice
	task automatic execute_word(input logic opn, input logic [5:0] op,
			input logic [2:0] ia, input logic [2:0] ib, input logic [2:0] ic,
			input logic [31:0] imm, input logic [7:0] vec, output machine_status_t r);
		logic [31:0] a, b, c;
		logic [1:0] p;
		logic priv, ranged;
		a = gpr[ia];
		b = gpr[ib];
		c = gpr[ic];
		p = a[1:0];
		r = '0;
		r.status = ST_OK;
		r.con = CON_NONE;
		priv = op == OP_LDPSW || op == OP_SPSWR || op == OP_LDPRM || op == OP_STPRM
			|| op == OP_SDOWN;
		ranged = op == OP_SETPR || op == OP_LDPSW || op == OP_SPSWR || op == OP_LDPRM
			|| op == OP_STPRM;
		if (opn == OPN_INTR)
			enter_interrupt({2'd0, vec});
		else if (op > OP_LAST)
			r.status = ST_ILL;
		else if (priv && !mode)
			r.status = ST_PRIV;
		else if (ranged && a >= NUM_PROCS)
			r.status = ST_RANGE;
		else begin
			case (op)
				OP_MSTRM: mode = 1'b1;
				OP_USERM: mode = 1'b0;
				OP_NINTR: ie = 1'b0;
				OP_INTRP: ie = 1'b1;
				OP_SETRI: gpr[ia] = imm;
				OP_SETRG: gpr[ia] = b;
				OP_SETPR: cur = p;
				OP_CPPRG: gpr[ia] = {30'd0, cur};
				OP_ADDRG: gpr[ia] = b + c;
				OP_SUBRG: gpr[ia] = b - c;
				OP_PSHRG: pmem[paddr(cur, sp - a[9:0])] = b;
				OP_POPRG: gpr[ib] = pmem[paddr(cur, sp + a[9:0])];
				OP_JMABS: pc = a[9:0];
				OP_JMPTO: pc = pc + a[9:0];
				OP_JZERO: if (a == 0) pc = pc + b[9:0];
				OP_JNZRO: if (a != 0) pc = pc + b[9:0];
				OP_JMBSI: pc = imm[9:0];
				OP_JMTOI: pc = pc + imm[9:0];
				OP_JZROI: if (a == 0) pc = pc + imm[9:0];
				OP_JNZRI: if (a != 0) pc = pc + imm[9:0];
				OP_LDMEM: gpr[ib] = pmem[paddr(cur, a[9:0])];
				OP_STMEM: begin
					if (mode && cur == KERNEL && a[9:0] == con_addr) begin
						if (b == 0) r.con = CON_IN;
						else if (b == 1) r.con = CON_OUT;
						else r.status = ST_CONS;
					end else
						pmem[paddr(cur, a[9:0])] = b;
				end
				OP_LDSHM: gpr[ib] = smem[a[9:0]];
				OP_STSHM: smem[a[9:0]] = b;
				OP_LDPSW: begin
					sp = pmem[paddr(p, frame)][9:0];
					pc = pmem[paddr(p, frame + 10'd1)][9:0];
					mode = pmem[paddr(p, frame + 10'd2)][0];
					for (int k = 0; k < 8; k++)
						gpr[k] = pmem[paddr(p, frame + 10'd3 + 10'(k))];
					cur = p;
					ie = 1'b1;
				end
				OP_SPSWR: pmem[paddr(p, frame + 10'd3 + 10'(ib))] = c;
				OP_LDPRM: gpr[ic] = pmem[paddr(p, b[9:0])];
				OP_STPRM: pmem[paddr(p, b[9:0])] = c;
				OP_WKCPU: begin
					r.sig = 1'b1;
					r.tgt = a;
					r.da = b;
					r.db = c;
				end
				OP_GETI0: gpr[ia] = {30'd0, last_proc};
				OP_GETI1: gpr[ia] = aux;
				OP_CLLSB: begin
					sp = sp - a[9:0];
					pmem[paddr(cur, sp)] = {22'd0, pc};
					pc = b[9:0];
				end
				OP_RETSB: begin
					pc = pmem[paddr(cur, sp)][9:0];
					sp = sp + a[9:0];
				end
				OP_CLINT: enter_interrupt(a[9:0]);
				OP_SDOWN: run = 1'b0;
				default: ;
			endcase
		end
		r.pc = pc;
		r.proc = cur;
		r.mode = mode;
		r.ie = ie;
		r.run = run;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		machine_status_t e;
		if (!arst_n) begin
			foreach (gpr[k]) gpr[k] = '0;
			pc = '0;
			sp = SP_RESET;
			cur = KERNEL;
			mode = 1'b1;
			ie = 1'b0;
			run = 1'b1;
			frame = 10'd0;
			pidslot = 10'd1;
			con_addr = 10'd2;
			last_proc = 2'd3;
			aux = '0;
			status_q.delete();
			mismatches = 0;
			words_seen = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_FRAME:   frame = cfg_data[9:0];
					CFG_PIDSLOT: pidslot = cfg_data[9:0];
					CFG_CONSOLE: con_addr = cfg_data[9:0];
					CFG_LASTPRC: last_proc = cfg_data[1:0];
					CFG_AUX:     aux = cfg_data;
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready) begin
				execute_word(in_ch.operation, in_ch.opcode, in_ch.reg_a, in_ch.reg_b,
					in_ch.reg_c, in_ch.immediate, in_ch.interrupt_number, e);
				status_q.push_back(e);
			end
			if (out_ch.valid && out_ch.ready) begin
				words_seen++;
				if (status_q.size() == 0) begin
					$error("result word with no pending instruction");
					mismatches++;
				end else begin
					e = status_q.pop_front();
					check_field("status", e.status, out_ch.status);
					check_field("program_counter", e.pc, out_ch.program_counter);
					check_field("process_number", e.proc, out_ch.process_number);
					check_field("master_mode", e.mode, out_ch.master_mode);
					check_field("interruptible", e.ie, out_ch.interruptible);
					check_field("running", e.run, out_ch.running);
					check_field("console_request", e.con, out_ch.console_request);
					check_field("signal_valid", e.sig, out_ch.signal_valid);
					check_field("signal_target", e.tgt, out_ch.signal_target);
					check_field("signal_data_a", e.da, out_ch.signal_data_a);
					check_field("signal_data_b", e.db, out_ch.signal_data_b);
				end
			end
		end
	end

endmodule

// File: sim/tb_toy_cpu_execute_unit.sv
// tb_toy_cpu_execute_unit: stimulus and verdict for the execute unit; fills every
// memory word first, then directed and random instruction words over several configs
// depends on tce_pkg, tce_in_if, tce_out_if, toy_cpu_execute_unit and tce_exec_checker
module tb_toy_cpu_execute_unit;
	import tce_pkg::*;

	localparam int IDLE_LIMIT = 5000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [31:0] cfg_data;
	int          mismatches, words_seen, words_sent, idle_cycles, stall;
	logic        no_idle;
	logic [9:0]  con_addr;

	tce_in_if  in_ch ();
	tce_out_if out_ch ();

	toy_cpu_execute_unit dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	tce_exec_checker chk (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.mismatches(mismatches), .words_seen(words_seen)
	);

	always #2 clk = ~clk;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	// result side stalls
	always @(posedge clk) begin
		if (stall > 0) begin
			out_ch.ready <= 1'b0;
			stall <= stall - 1;
		end else begin
			out_ch.ready <= 1'b1;
			if (!no_idle && $urandom_range(0, 9) == 0)
				stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
					: $urandom_range(1, 3);
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send(input logic opn, input logic [5:0] op, input logic [2:0] ra,
			input logic [2:0] rb, input logic [2:0] rc, input logic [31:0] imm,
			input logic [7:0] vec);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.operation <= opn;
		in_ch.opcode <= op;
		in_ch.reg_a <= ra;
		in_ch.reg_b <= rb;
		in_ch.reg_c <= rc;
		in_ch.immediate <= imm;
		in_ch.interrupt_number <= vec;
		do @(posedge clk); while (!in_ch.ready);
		words_sent++;
	endtask

	task automatic exec(input logic [5:0] op, input logic [2:0] ra, input logic [2:0] rb,
			input logic [2:0] rc, input logic [31:0] imm);
		send(OPN_EXEC, op, ra, rb, rc, imm, 8'($urandom));
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (words_seen != words_sent) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [2:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_CONSOLE) con_addr = val[9:0];
	endtask

	task automatic set_config(input logic [9:0] fr, input logic [9:0] pid,
			input logic [9:0] con, input logic [1:0] lp, input logic [31:0] ax);
		drain();
		write_cfg(CFG_FRAME, {22'($urandom), fr});
		write_cfg(CFG_PIDSLOT, {22'($urandom), pid});
		write_cfg(CFG_CONSOLE, {22'($urandom), con});
		write_cfg(CFG_LASTPRC, {30'($urandom), lp});
		write_cfg(CFG_AUX, ax);
	endtask

	function automatic logic [31:0] pick_imm();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 3);
			1: return $urandom_range(0, 1023);
			2: return -$urandom_range(1, 1024);
			default: return $urandom;
		endcase
	endfunction

	task automatic random_words(input int n);
		int r;
		logic [2:0] ra, rb;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			ra = 3'($urandom);
			rb = 3'($urandom);
			if (r < 6)
				send(OPN_INTR, 6'($urandom), ra, rb, 3'($urandom), $urandom, 8'($urandom));
			else if (r < 22)
				exec(OP_SETRI, ra, rb, 3'($urandom), pick_imm());
			else if (r < 28)
				exec(OP_MSTRM, ra, rb, 3'($urandom), $urandom);
			else if (r < 31) begin
				// console store sequence, data 0, 1 or a bad code
				exec(OP_SETRI, ra, 3'($urandom), 3'($urandom), {22'($urandom), con_addr});
				exec(OP_SETRI, rb, 3'($urandom), 3'($urandom), $urandom_range(0, 2));
				if (ra != rb) exec(OP_STMEM, ra, rb, 3'($urandom), $urandom);
			end else if (r < 34)
				exec(6'($urandom_range(38, 63)), ra, rb, 3'($urandom), $urandom);
			else
				exec(6'($urandom_range(0, 37)), ra, rb, 3'($urandom), pick_imm());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.operation = OPN_EXEC;
		in_ch.opcode = '0;
		in_ch.reg_a = '0;
		in_ch.reg_b = '0;
		in_ch.reg_c = '0;
		in_ch.immediate = '0;
		in_ch.interrupt_number = '0;
		out_ch.ready = 1'b0;
		stall = 0;
		no_idle = 1'b1;
		words_sent = 0;
		idle_cycles = 0;
		con_addr = 10'd2;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_config(10'd0, 10'd1, 10'd2, 2'd3, 32'd0);

		// fill every word so no read ever hits an unwritten location
		for (int p = 0; p < NUM_PROCS; p++) begin
			exec(OP_SETRI, 3'd1, 3'd0, 3'd0, p);
			for (int w = 0; w < WORDS_PER_PROC; w++) begin
				if (w % 8 == 0) exec(OP_SETRI, 3'd3, 3'd0, 3'd0, $urandom);
				exec(OP_SETRI, 3'd2, 3'd0, 3'd0, w);
				exec(OP_STPRM, 3'd1, 3'd2, 3'd3, 0);
			end
		end
		for (int w = 0; w < WORDS_PER_PROC; w++) begin
			exec(OP_SETRI, 3'd3, 3'd0, 3'd0, $urandom);
			exec(OP_SETRI, 3'd2, 3'd0, 3'd0, w);
			exec(OP_STSHM, 3'd2, 3'd3, 3'd0, 0);
		end
		no_idle = 1'b0;

		// directed: console codes, faults, process switch and interrupts, extremes
		exec(OP_SETRI, 3'd1, 3'd0, 3'd0, con_addr);
		exec(OP_SETRI, 3'd2, 3'd0, 3'd0, 0);
		exec(OP_STMEM, 3'd1, 3'd2, 3'd0, 0);
		exec(OP_SETRI, 3'd2, 3'd0, 3'd0, 1);
		exec(OP_STMEM, 3'd1, 3'd2, 3'd0, 0);
		exec(OP_SETRI, 3'd2, 3'd0, 3'd0, 32'hffff_ffff);
		exec(OP_STMEM, 3'd1, 3'd2, 3'd0, 0);
		exec(6'd63, 3'd7, 3'd7, 3'd7, 32'hffff_ffff);
		exec(OP_SETRI, 3'd4, 3'd0, 3'd0, 32'h8000_0000);
		exec(OP_SETPR, 3'd4, 3'd0, 3'd0, 0);
		exec(OP_USERM, 3'd0, 3'd0, 3'd0, 0);
		exec(OP_SDOWN, 3'd0, 3'd0, 3'd0, 0);
		exec(OP_MSTRM, 3'd0, 3'd0, 3'd0, 0);
		exec(OP_WKCPU, 3'd1, 3'd2, 3'd4, 0);
		exec(OP_SETRI, 3'd4, 3'd0, 3'd0, 2);
		exec(OP_SETPR, 3'd4, 3'd0, 3'd0, 0);
		send(OPN_INTR, OP_NOPER, 3'd0, 3'd0, 3'd0, 0, 8'd255);
		exec(OP_CLINT, 3'd2, 3'd0, 3'd0, 0);
		exec(OP_JMBSI, 3'd0, 3'd0, 3'd0, 32'h7fff_ffff);
		exec(OP_JMTOI, 3'd0, 3'd0, 3'd0, 32'h8000_0000);
		exec(OP_SETRI, 3'd4, 3'd0, 3'd0, 1);
		exec(OP_LDPSW, 3'd4, 3'd0, 3'd0, 0);
		exec(OP_SDOWN, 3'd0, 3'd0, 3'd0, 0);

		random_words(300);
		set_config(10'd0, 10'd0, 10'd0, 2'd0, 32'h8000_0000);
		no_idle = 1'b1;
		random_words(300);
		no_idle = 1'b0;
		set_config(10'd1023, 10'd1023, 10'd1023, 2'd3, 32'h7fff_ffff);
		random_words(300);
		set_config(10'($urandom), 10'($urandom), 10'($urandom), 2'($urandom), $urandom);
		random_words(300);
		drain();

		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: filelist.f
rtl/tce_pkg.sv
rtl/tce_in_if.sv
rtl/tce_out_if.sv
rtl/tce_ram.sv
rtl/toy_cpu_execute_unit.sv
sim/tce_exec_checker.sv
sim/tb_toy_cpu_execute_unit.sv
